FILE: rtl/phong_specular_tint_shade_defines.svh
// ----------------------------------------------------------------------------
// Phong specular tint shader: assertion macros
// Shared concurrent assertion forms used by the shader RTL.
// ----------------------------------------------------------------------------
`ifndef PHONG_SPECULAR_TINT_SHADE_DEFINES_SVH
`define PHONG_SPECULAR_TINT_SHADE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define PST_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/pst_pkg.sv
// ----------------------------------------------------------------------------
// Phong specular tint shader package
// Payload types, register indexes and the shared Q1.15 multiply.
// ----------------------------------------------------------------------------
package pst_pkg;

   localparam int unsigned EXP_BITS_DEFAULT = 8;
   localparam int unsigned SHIN_W           = 8;
   localparam int unsigned CSR_IDX_W        = 8;
   localparam int unsigned CSR_DATA_W       = 16;

   localparam logic [15:0] ONE_Q15 = 16'h8000;

   localparam logic [CSR_IDX_W-1:0] CSR_TINT_RED   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TINT_GREEN = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TINT_BLUE  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SHININESS  = 8'd3;

   typedef struct packed {
      logic signed [15:0] in_dir_x;
      logic signed [15:0] in_dir_y;
      logic signed [15:0] in_dir_z;
      logic signed [15:0] out_dir_x;
      logic signed [15:0] out_dir_y;
      logic signed [15:0] out_dir_z;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
   } rsp_payload_type;

   // Running product and running square of one exponentiation.
   typedef struct packed {
      logic [15:0] spec;
      logic [15:0] base;
   } pow_state_type;

   // Q1.15 product, rounded to nearest with ties up. Inputs never exceed one,
   // so the result fits in 16 bits.
   function automatic logic [15:0] mul_q15(input logic [15:0] a, input logic [15:0] b);
      logic [31:0] prod;
      prod = (32'(a) * 32'(b)) + 32'd16384;
      return prod[30:15];
   endfunction

endpackage

FILE: rtl/phong_specular_tint_shade.sv
// ----------------------------------------------------------------------------
// Phong specular tint shader
// Mirrors the incident vector about the normal, takes the clamped cosine with
// the outgoing vector, raises it to the shininess and blends each tint.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one shading query per item: incident, outgoing
//   and normal vectors in signed Q2.14. The rsp_ channel returns one item per
//   query with red, green and blue reflectance in Q1.15, in query order.
//   The csr_ channel writes the three tints and the shininess; it is always
//   ready and must only be used while no query is in flight.
//   From acceptance to rsp_valid a query passes six vector-math stages, one
//   stage per exponent bit (EXP_BITS defaults to 8), and one blend stage
//   that is the output register. Throughput is one item per cycle while
//   the output does not stall. All stages move together on one advance
//   enable, so the rate is set by that enable and the output register:
//   when the receiver holds rsp_ready low with a result waiting, the whole
//   pipeline freezes, req_ready drops, and nothing is lost or repeated.
//   Bubbles in the pipeline are not squeezed out during a stall.
//   Synchronous reset clears all valid bits and loads tints of zero and a
//   shininess of one; payload registers are not reset.
// ----------------------------------------------------------------------------
`include "phong_specular_tint_shade_defines.svh"

module phong_specular_tint_shade #(
   parameter int unsigned EXP_BITS = pst_pkg::EXP_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  pst_pkg::req_payload_type       req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output pst_pkg::rsp_payload_type       rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pst_pkg::CSR_DATA_W-1:0] csr_data
);
   import pst_pkg::*;

   // Only the low shininess bits that exist in the register can matter.
   localparam int unsigned POW_STAGES = (EXP_BITS < SHIN_W) ? EXP_BITS : SHIN_W;

   // Configuration registers.
   logic [15:0]       tint_red_ff;
   logic [15:0]       tint_green_ff;
   logic [15:0]       tint_blue_ff;
   logic [SHIN_W-1:0] shin_ff;

   // The whole pipeline advances when the output register is empty or drained.
   logic pipe_adv;

   // Stage valid bits.
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic rsp_valid_ff;

   // Unpacked views of the query.
   logic signed [15:0] iv [3];
   logic signed [15:0] ov [3];
   logic signed [15:0] nv [3];

   // Stage 1: n_j * i_j.
   logic signed [31:0] ni_in [3];
   logic signed [31:0] ni_ff [3];
   logic signed [15:0] i1_ff [3];
   logic signed [15:0] o1_ff [3];
   logic signed [15:0] n1_ff [3];

   // Stage 2: d = n.i in Q5.28.
   logic signed [32:0] d2_in;
   logic signed [32:0] d2_ff;
   logic signed [15:0] i2_ff [3];
   logic signed [15:0] o2_ff [3];
   logic signed [15:0] n2_ff [3];

   // Stage 3: d * n_j.
   logic signed [48:0] dn3_in [3];
   logic signed [48:0] dn3_ff [3];
   logic signed [15:0] i3_ff [3];
   logic signed [15:0] o3_ff [3];

   // Stage 4: mirror vector, floored to Q28.
   logic signed [49:0] r42 [3];
   logic signed [35:0] r4_in [3];
   logic signed [35:0] r4_ff [3];
   logic signed [15:0] o4_ff [3];

   // Stage 5: r_j * o_j.
   logic signed [51:0] ro5_in [3];
   logic signed [51:0] ro5_ff [3];

   // Stage 6: cosine, clamped to [0, 1] in Q1.15.
   logic signed [53:0] dot6;
   logic [15:0]        v6_in;
   logic [15:0]        v6_ff;

   // Exponent chain; entry zero is the stage 6 output.
   logic          pow_valid [POW_STAGES+1];
   pow_state_type pow_st    [POW_STAGES+1];

   // Output register.
   rsp_payload_type rsp_data_in;
   rsp_payload_type rsp_data_ff;

   // Tint saturated to one, then c + (1 - c) * spec.
   function automatic logic [15:0] blend(input logic [15:0] tint, input logic [15:0] spec);
      logic [15:0] t;
      t = (tint > ONE_Q15) ? ONE_Q15 : tint;
      return t + mul_q15(ONE_Q15 - t, spec);
   endfunction

   // ---------------------------------------------------------------------
   // Configuration port. Writes to unknown indexes are dropped.
   // ---------------------------------------------------------------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_red_ff   <= '0;
         tint_green_ff <= '0;
         tint_blue_ff  <= '0;
         shin_ff       <= SHIN_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_TINT_RED:   tint_red_ff   <= csr_data;
            CSR_TINT_GREEN: tint_green_ff <= csr_data;
            CSR_TINT_BLUE:  tint_blue_ff  <= csr_data;
            CSR_SHININESS:  shin_ff       <= csr_data[SHIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Flow control.
   // ---------------------------------------------------------------------
   assign pipe_adv  = !rsp_valid_ff || rsp_ready;
   assign req_ready = pipe_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         rsp_valid_ff <= pow_valid[POW_STAGES];
      end
   end

   // ---------------------------------------------------------------------
   // Vector datapath. All products are exact; the only rounding is the
   // floor of the mirror vector and the floor of the final cosine.
   // ---------------------------------------------------------------------
   always_comb begin
      iv[0] = req_data.in_dir_x;
      iv[1] = req_data.in_dir_y;
      iv[2] = req_data.in_dir_z;
      ov[0] = req_data.out_dir_x;
      ov[1] = req_data.out_dir_y;
      ov[2] = req_data.out_dir_z;
      nv[0] = req_data.norm_x;
      nv[1] = req_data.norm_y;
      nv[2] = req_data.norm_z;
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ni_in[j]  = iv[j] * nv[j];
         dn3_in[j] = 49'(d2_ff) * 49'(n2_ff[j]);
         // i * 2^28 - 2 * d * n, then an arithmetic shift floors to Q28.
         r42[j]    = (50'(i3_ff[j]) <<< 28) - (50'(dn3_ff[j]) <<< 1);
         r4_in[j]  = 36'(r42[j] >>> 14);
         ro5_in[j] = 52'(r4_ff[j]) * 52'(o4_ff[j]);
      end
      d2_in = 33'(ni_ff[0]) + 33'(ni_ff[1]) + 33'(ni_ff[2]);
      dot6  = 54'(ro5_ff[0]) + 54'(ro5_ff[1]) + 54'(ro5_ff[2]);
   end

   // A non-positive cosine gives zero; anything at or above one saturates.
   always_comb begin
      priority if (dot6 <= 54'sd0) begin
         v6_in = '0;
      end else if (dot6[53:27] > 27'(ONE_Q15)) begin
         v6_in = ONE_Q15;
      end else begin
         v6_in = dot6[42:27];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         for (int j = 0; j < 3; j++) begin
            ni_ff[j]  <= ni_in[j];
            i1_ff[j]  <= iv[j];
            o1_ff[j]  <= ov[j];
            n1_ff[j]  <= nv[j];
            i2_ff[j]  <= i1_ff[j];
            o2_ff[j]  <= o1_ff[j];
            n2_ff[j]  <= n1_ff[j];
            dn3_ff[j] <= dn3_in[j];
            i3_ff[j]  <= i2_ff[j];
            o3_ff[j]  <= o2_ff[j];
            r4_ff[j]  <= r4_in[j];
            o4_ff[j]  <= o3_ff[j];
            ro5_ff[j] <= ro5_in[j];
         end
         d2_ff <= d2_in;
         v6_ff <= v6_in;
      end
   end

   // ---------------------------------------------------------------------
   // Square-and-multiply from the least significant shininess bit. The
   // product starts at one, so a shininess of zero yields one.
   // ---------------------------------------------------------------------
   assign pow_valid[0]   = s6_valid_ff;
   assign pow_st[0].spec = ONE_Q15;
   assign pow_st[0].base = v6_ff;

   for (genvar k = 0; k < POW_STAGES; k++) begin : g_pow
      pst_pow_stage u_pow_stage (
         .clock      (clock),
         .reset      (reset),
         .adv        (pipe_adv),
         .exp_bit    (shin_ff[k]),
         .prev_valid (pow_valid[k]),
         .prev_pow   (pow_st[k]),
         .valid      (pow_valid[k+1]),
         .pow        (pow_st[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Tint blend into the output register.
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_data_in.red_out   = blend(tint_red_ff,   pow_st[POW_STAGES].spec);
      rsp_data_in.green_out = blend(tint_green_ff, pow_st[POW_STAGES].spec);
      rsp_data_in.blue_out  = blend(tint_blue_ff,  pow_st[POW_STAGES].spec);
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------
   `PST_ASSERT_IMPL(a_cos_range, clock, reset, s6_valid_ff, v6_ff <= ONE_Q15, "cosine above one")

   `PST_ASSERT_IMPL(a_zero_shin, clock, reset, pow_valid[POW_STAGES] && (shin_ff[POW_STAGES-1:0] == '0), pow_st[POW_STAGES].spec == ONE_Q15, "zero shininess not one")

   `PST_ASSERT_IMPL(a_rsp_range, clock, reset, rsp_valid, (rsp_data.red_out <= ONE_Q15) && (rsp_data.green_out <= ONE_Q15) && (rsp_data.blue_out <= ONE_Q15), "reflectance above one")

   `PST_ASSERT_NEXT(a_stall_hold, clock, reset, !pipe_adv, $stable(s1_valid_ff) && $stable(s6_valid_ff) && $stable(v6_ff), "pipeline moved during stall")

endmodule

FILE: rtl/pst_pow_stage.sv
// ----------------------------------------------------------------------------
// Phong specular tint shader: one square-and-multiply stage
// Handles one exponent bit: optional multiply into the product, then square.
// ----------------------------------------------------------------------------
module pst_pow_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   exp_bit,
   input  logic                   prev_valid,
   input  pst_pkg::pow_state_type prev_pow,
   output logic                   valid,
   output pst_pkg::pow_state_type pow
);
   import pst_pkg::*;

   logic          valid_ff;
   pow_state_type pow_ff;
   pow_state_type pow_in;

   always_comb begin
      pow_in.spec = exp_bit ? mul_q15(prev_pow.spec, prev_pow.base) : prev_pow.spec;
      pow_in.base = mul_q15(prev_pow.base, prev_pow.base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pow_ff <= pow_in;
      end
   end

   assign valid = valid_ff;
   assign pow   = pow_ff;

endmodule

FILE: verif/tb_phong_specular_tint_shade.sv
// ----------------------------------------------------------------------------
// Phong specular tint shader testbench
// Sends shading queries through the req_ channel while changing the tints and
// the shininess between phases, and checks every result item against a typed
// value or a fixed-point predictor of mirror, clamped cosine, power and blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_phong_specular_tint_shade;

   import pst_pkg::*;

   // Pipeline depth with the default exponent width: six vector stages, eight
   // power stages and the blend stage.
   localparam int PIPE_LAT = 15;
   // Indexes from here on select no register and must be ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SPARE = 8'd4;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_ITEMS = 125;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   // Shading settings as the block should hold them.
   logic [15:0] tint_r_now = 16'd0;
   logic [15:0] tint_g_now = 16'd0;
   logic [15:0] tint_b_now = 16'd0;
   logic [7:0]  shin_now   = 8'd1;

   // Results owed by the block, oldest first.
   rsp_payload_type shade_q[$];

   // A directed item may carry a typed-in result; it travels with the item.
   logic            typed_on   = 1'b0;
   rsp_payload_type typed_want = '0;

   int fails = 0;
   int queries_sent = 0;
   int results_seen = 0;
   int reg_writes = 0;
   bit calm_tx = 1'b0;
   bit calm_rx = 1'b0;
   int stall_left = 0;
   int mode_left = 0;

   phong_specular_tint_shade DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Fixed-point prediction.

   // Q1.15 product with round to nearest, ties up.
   function automatic logic [15:0] q15_mul(input logic [15:0] a, input logic [15:0] b);
      longint aa, bb;
      aa = a;
      bb = b;
      return 16'((aa * bb + 64'sd16384) >>> 15);
   endfunction

   // Tint plus the specular share of what the tint leaves; tints above one
   // count as one.
   function automatic logic [15:0] tint_blend(input logic [15:0] c, input logic [15:0] spec);
      logic [15:0] t;
      t = (c > ONE_Q15) ? ONE_Q15 : c;
      return t + q15_mul(ONE_Q15 - t, spec);
   endfunction

   function automatic rsp_payload_type shade_expect(input req_payload_type q);
      longint iv[3], ov[3], nv[3], rr[3];
      longint ndoti, rdoto, cosq;
      logic [15:0] cosv, spec, base;
      rsp_payload_type p;
      iv[0] = q.in_dir_x;  iv[1] = q.in_dir_y;  iv[2] = q.in_dir_z;
      ov[0] = q.out_dir_x; ov[1] = q.out_dir_y; ov[2] = q.out_dir_z;
      nv[0] = q.norm_x;    nv[1] = q.norm_y;    nv[2] = q.norm_z;
      ndoti = nv[0] * iv[0] + nv[1] * iv[1] + nv[2] * iv[2];
      // Mirror in Q42, then floored to Q28; the arithmetic shift floors.
      for (int j = 0; j < 3; j++) begin
         rr[j] = ((iv[j] <<< 28) - 2 * ndoti * nv[j]) >>> 14;
      end
      rdoto = rr[0] * ov[0] + rr[1] * ov[1] + rr[2] * ov[2];
      if (rdoto <= 0) begin
         cosv = 16'd0;
      end else begin
         cosq = rdoto >>> 27;
         cosv = (cosq > 32768) ? ONE_Q15 : 16'(cosq);
      end
      // Square-and-multiply from the least significant exponent bit.
      spec = ONE_Q15;
      base = cosv;
      for (int k = 0; k < 8; k++) begin
         if (shin_now[k]) begin
            spec = q15_mul(spec, base);
         end
         base = q15_mul(base, base);
      end
      p.red_out   = tint_blend(tint_r_now, spec);
      p.green_out = tint_blend(tint_g_now, spec);
      p.blue_out  = tint_blend(tint_b_now, spec);
      return p;
   endfunction

   // Stimulus helpers.

   function automatic req_payload_type vec(input int ix, input int iy, input int iz,
                                           input int ox, input int oy, input int oz,
                                           input int nx, input int ny, input int nz);
      req_payload_type q;
      q.in_dir_x  = 16'(ix); q.in_dir_y  = 16'(iy); q.in_dir_z  = 16'(iz);
      q.out_dir_x = 16'(ox); q.out_dir_y = 16'(oy); q.out_dir_z = 16'(oz);
      q.norm_x    = 16'(nx); q.norm_y    = 16'(ny); q.norm_z    = 16'(nz);
      return q;
   endfunction

   function automatic int jitter(input int w);
      return int'($urandom_range(0, 2 * w)) - w;
   endfunction

   function automatic int clamp16(input longint x);
      return (x > 32767) ? 32767 : ((x < -32768) ? -32768 : int'(x));
   endfunction

   // Mostly no pause, often a short one, now and then a long one.
   function automatic int draw_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_tint();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         return 16'd0;
      end else if (r < 30) begin
         return ONE_Q15;
      end else if (r < 40) begin
         return 16'($urandom_range(32769, 65535));
      end
      return 16'($urandom_range(0, 32768));
   endfunction

   // Most queries are built so that the outgoing vector sits near the mirror
   // of the incident one, which keeps the cosine positive and the power busy.
   // The rest are raw bit patterns or have a vector zeroed out.
   function automatic req_payload_type rand_query();
      int pick, ax;
      longint iv[3], nv[3], ov[3], ndoti;
      req_payload_type q;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         for (int k = 0; k < 9; k++) begin
            q[k * 16 +: 16] = 16'($urandom_range(0, 65535));
         end
         if (pick >= 25) begin
            if ($urandom_range(0, 1)) begin
               q.norm_x = '0; q.norm_y = '0; q.norm_z = '0;
            end else begin
               q.out_dir_x = '0; q.out_dir_y = '0; q.out_dir_z = '0;
            end
         end
         return q;
      end
      ax = $urandom_range(0, 2);
      for (int j = 0; j < 3; j++) begin
         nv[j] = (j == ax) ? (($urandom_range(0, 1) ? 16384 : -16384) + jitter(2000))
                           : jitter(4000);
         iv[j] = jitter(16384);
      end
      ndoti = nv[0] * iv[0] + nv[1] * iv[1] + nv[2] * iv[2];
      for (int j = 0; j < 3; j++) begin
         ov[j] = iv[j] - ((2 * ndoti * nv[j]) >>> 28) + jitter(1500);
         // An occasional long outgoing vector pushes the cosine past one.
         if (pick > 94) begin
            ov[j] = 2 * ov[j];
         end
      end
      return vec(int'(iv[0]), int'(iv[1]), int'(iv[2]),
                 clamp16(ov[0]), clamp16(ov[1]), clamp16(ov[2]),
                 int'(nv[0]), int'(nv[1]), int'(nv[2]));
   endfunction

   // Driving tasks. Each leaves its valid high after the last acceptance so
   // that the caller lowers it once.

   task automatic send_query(input req_payload_type q, input bit typed,
                             input rsp_payload_type want);
      req_valid  <= 1'b1;
      req_data   <= q;
      typed_on   <= typed;
      typed_want <= want;
      do @(posedge clock); while (!req_ready);
      queries_sent++;
   endtask

   task automatic pause_sender();
      int g;
      g = calm_tx ? 0 : draw_pause();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Wait until every owed result is back, then let the pipeline drain.
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (shade_q.size() != 0);
      repeat (PIPE_LAT + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      reg_writes++;
      case (idx)
         CSR_TINT_RED:   tint_r_now = val;
         CSR_TINT_GREEN: tint_g_now = val;
         CSR_TINT_BLUE:  tint_b_now = val;
         CSR_SHININESS:  shin_now   = val[7:0];
         default: ;
      endcase
   endtask

   // Writes all four registers plus one unused index, which must change
   // nothing. Only the low byte of the shininess data counts.
   task automatic program_regs(input logic [15:0] tr, input logic [15:0] tg,
                               input logic [15:0] tb, input logic [15:0] sh);
      write_reg(CSR_TINT_RED, tr);
      write_reg(CSR_TINT_GREEN, tg);
      write_reg(CSR_TINT_BLUE, tb);
      write_reg(CSR_SHININESS, sh);
      write_reg(CSR_IDX_W'($urandom_range(CSR_FIRST_SPARE, 255)),
                16'($urandom_range(0, 65535)));
      csr_valid <= 1'b0;
   endtask

   // Directed plan: settings for the row, the query, and a typed-in result
   // where it is plain from the math.
   typedef struct {
      logic [15:0]     tr, tg, tb, sh;
      req_payload_type q;
      bit              typed;
      rsp_payload_type want;
   } plan_row_type;

   plan_row_type plan[$];

   task automatic add_row(input logic [15:0] tr, input logic [15:0] tg,
                          input logic [15:0] tb, input logic [15:0] sh,
                          input req_payload_type q, input bit typed,
                          input rsp_payload_type want);
      plan_row_type row;
      row.tr = tr; row.tg = tg; row.tb = tb; row.sh = sh;
      row.q = q; row.typed = typed; row.want = want;
      plan.push_back(row);
   endtask

   // Receiver: pauses of random length, with calm stretches where it is
   // always ready.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         calm_rx = ($urandom_range(0, 3) == 0);
         mode_left = $urandom_range(50, 300);
      end else begin
         mode_left--;
      end
      if (stall_left == 0 && !calm_rx) begin
         stall_left = draw_pause();
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_channel(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fails++;
      end
   endtask

   // Predict on acceptance and compare on delivery. Settings only change while
   // no query is in flight, so predicting at acceptance is exact.
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            shade_q.push_back(typed_on ? typed_want : shade_expect(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (shade_q.size() == 0) begin
               $display("%0t: unexpected result item, expected none, actual %h",
                        $time, rsp_data);
               fails++;
            end else begin
               want = shade_q.pop_front();
               check_channel("red_out", want.red_out, rsp_data.red_out);
               check_channel("green_out", want.green_out, rsp_data.green_out);
               check_channel("blue_out", want.blue_out, rsp_data.blue_out);
            end
         end
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #1000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      rsp_payload_type none, zero3, one3;
      logic [15:0] cur_tr, cur_tg, cur_tb, cur_sh;
      none  = '0;
      zero3 = '{16'd0, 16'd0, 16'd0};
      one3  = '{ONE_Q15, ONE_Q15, ONE_Q15};

      // Settings after reset: no tint and a shininess of one, so each channel
      // simply carries the clamped cosine.
      add_row(0, 0, 0, 1, vec(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero3);
      // Straight down onto an upward normal, viewed from straight above.
      add_row(0, 0, 0, 1, vec(0, 0, -16384, 0, 0, 16384, 0, 0, 16384), 1, one3);
      // Negative cosine: viewer below the surface.
      add_row(0, 0, 0, 1, vec(0, 0, -16384, 0, 0, -16384, 0, 0, 16384), 1, zero3);
      // Cosine above one from a long outgoing vector saturates.
      add_row(0, 0, 0, 1, vec(0, 0, -16384, 0, 0, 32767, 0, 0, 16384), 1, one3);
      // Field extremes and alternating bit patterns.
      add_row(0, 0, 0, 1, vec(32767, 32767, 32767, 32767, 32767, 32767,
                              32767, 32767, 32767), 0, none);
      add_row(0, 0, 0, 1, vec(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768), 0, none);
      add_row(0, 0, 0, 1, vec(21845, -21846, 21845, -21846, 21845, -21846,
                              21845, -21846, 21845), 0, none);
      // Vectors that are not unit length are taken as they are.
      add_row(0, 0, 0, 1, vec(8192, 0, -8192, 8192, 0, 8192, 0, 0, 16384), 0, none);
      add_row(0, 0, 0, 1, vec(3000, -5000, -20000, 2500, 4000, 9000,
                              1000, 500, 12000), 0, none);
      // Zero shininess gives full specular even with a zero cosine; red tint
      // above one saturates.
      add_row(16'hFFFF, ONE_Q15, 0, 0, vec(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, one3);
      add_row(16'hFFFF, ONE_Q15, 0, 0, vec(-32768, -32768, -32768, -32768, -32768,
                                           -32768, -32768, -32768, -32768), 1, one3);
      // Largest shininess: a full cosine stays one, a zero cosine leaves the tint.
      add_row(ONE_Q15, 16384, 1, 255, vec(0, 0, -16384, 0, 0, 16384, 0, 0, 16384),
              1, one3);
      add_row(ONE_Q15, 16384, 1, 255, vec(0, 0, -16384, 0, 0, -16384, 0, 0, 16384),
              1, '{ONE_Q15, 16'd16384, 16'd1});
      add_row(ONE_Q15, 16384, 1, 255, vec(0, -11585, -11585, 0, 11585, 11585,
                                          0, 0, 16384), 0, none);
      add_row(ONE_Q15, 16384, 1, 255, vec(0, -11585, -11585, 0, 16000, 4000,
                                          0, 0, 16384), 0, none);
      // Shininess data with upper bits set: only the low byte counts.
      add_row(12345, 40000, 100, 16'h1F02, vec(0, -11585, -11585, 0, 11585, 14000,
                                               0, 0, 16384), 0, none);
      add_row(12345, 40000, 100, 16'h1F02, vec(32767, 32767, 32767, 32767, 32767,
                                               32767, 32767, 32767, 32767), 0, none);
      add_row(12345, 40000, 100, 16'h0080, vec(-9000, 4000, -12000, -7000, 3000,
                                               13000, 0, 0, 16384), 0, none);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      cur_tr = 0; cur_tg = 0; cur_tb = 0; cur_sh = 1;
      foreach (plan[k]) begin
         if (plan[k].tr != cur_tr || plan[k].tg != cur_tg ||
             plan[k].tb != cur_tb || plan[k].sh != cur_sh) begin
            settle();
            program_regs(plan[k].tr, plan[k].tg, plan[k].tb, plan[k].sh);
            cur_tr = plan[k].tr; cur_tg = plan[k].tg;
            cur_tb = plan[k].tb; cur_sh = plan[k].sh;
         end else begin
            pause_sender();
         end
         send_query(plan[k].q, plan[k].typed, plan[k].want);
      end

      // Random phases, each with fresh settings. The first three pin the
      // shininess to its extremes and its top bit.
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         logic [15:0] sh;
         settle();
         case (ph)
            0: sh = 16'h00FF;
            1: sh = 16'h0000;
            2: sh = 16'h0080;
            default: sh = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                      : 16'($urandom_range(1, 12));
         endcase
         if (ph == 0) begin
            program_regs(16'd0, ONE_Q15, 16'hFFFF, sh);
         end else begin
            program_regs(pick_tint(), pick_tint(), pick_tint(), sh);
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 40 == 0) begin
               calm_tx = ($urandom_range(0, 3) == 0);
            end
            pause_sender();
            send_query(rand_query(), 1'b0, none);
         end
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (shade_q.size() != 0);
      repeat (PIPE_LAT + 5) @(posedge clock);

      $display("Sent %0d shading queries and checked %0d result items.",
               queries_sent, results_seen);
      $display("Made %0d register writes over %0d settings, spare indexes included.",
               reg_writes, RAND_PHASES + 4);
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
